FILE: hw/rtl/hrhp_pkg.sv
package hrhp_pkg;

  localparam logic [1:0] PhLine = 2'd0;
  localparam logic [1:0] PhHead = 2'd1;
  localparam logic [1:0] PhDone = 2'd2;
  localparam logic [1:0] PhFail = 2'd3;

  localparam logic [2:0] PosMethod  = 3'd0;
  localparam logic [2:0] PosTarget  = 3'd1;
  localparam logic [2:0] PosLit     = 3'd2;
  localparam logic [2:0] PosVersion = 3'd7;

  localparam logic [2:0] RoleMethod  = 3'd0;
  localparam logic [2:0] RoleTarget  = 3'd1;
  localparam logic [2:0] RoleVersion = 3'd2;
  localparam logic [2:0] RoleSep     = 3'd3;
  localparam logic [2:0] RoleHeader  = 3'd4;
  localparam logic [2:0] RoleTerm    = 3'd5;
  localparam logic [2:0] RoleIgnored = 3'd6;

  localparam logic [2:0] VerNone     = 3'd0;
  localparam logic [2:0] VerAccept   = 3'd1;
  localparam logic [2:0] VerReject   = 3'd2;
  localparam logic [2:0] VerHdrEnd   = 3'd3;
  localparam logic [2:0] VerComplete = 3'd4;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;

  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] pos;
    logic       bad;
    logic       colon;
  } hrhp_line_t;

  typedef struct packed {
    hrhp_line_t st;
    logic [2:0] role;
  } hrhp_step_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] role;
    logic [2:0] verdict;
    logic       last;
  } hrhp_res_t;

  // expected character of the protocol literal "HTTP/"
  function automatic logic [7:0] proto_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic hrhp_step_t take_content(hrhp_line_t s, logic [7:0] b);
    hrhp_step_t r;
    logic [2:0] idx;
    r.st = s;
    r.role = RoleSep;
    idx = s.pos - PosLit;
    if (s.phase == PhHead) begin
      if (b == ChColon) r.st.colon = 1'b1;
      r.role = RoleHeader;
    end else if (!s.bad) begin
      case (s.pos)
        PosMethod: begin
          if (b == ChSp) r.st.pos = PosTarget;
          else r.role = RoleMethod;
        end
        PosTarget: begin
          if (b == ChSp) r.st.pos = PosLit;
          else r.role = RoleTarget;
        end
        PosVersion: begin
          if (b == ChSp) r.st.bad = 1'b1;
          else r.role = RoleVersion;
        end
        default: begin
          if (b == proto_char(idx)) r.st.pos = s.pos + 3'd1;
          else r.st.bad = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/http_request_head_parser.sv
// Each result beat is registered into the result queue when its input is taken.
// Throughput: one input beat per cycle; a line end or a late CR yields two
// result beats, which drain through a four-entry queue at one a cycle while the
// output is ready. The input stalls while fewer than two queue slots are free.
// Reset: asynchronous, active low; clears parser state and empties the queue.
module http_request_head_parser
  import hrhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [5:0] m_axis_tuser,   // [2:0] role, [5:3] verdict
  output logic       m_axis_tlast    // last
);

  hrhp_line_t st_q, st_d;
  logic       cr_q, cr_d;
  hrhp_res_t  r0, r1;
  logic [1:0] n;
  logic [2:0] verdict;
  hrhp_step_t t_cr, t_after_cr, t_plain;
  hrhp_line_t st_end;

  hrhp_res_t  fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] count_q, count_d;
  logic       s_acc, m_acc;
  hrhp_res_t  head;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count_q <= 3'd2);
  assign m_axis_tvalid = (count_q != 3'd0);

  assign t_cr       = take_content(st_q, ChCr);
  assign t_after_cr = take_content(t_cr.st, s_axis_tdata);
  assign t_plain    = take_content(st_q, s_axis_tdata);

  always_comb begin
    st_end = st_q;
    st_end.pos = PosMethod;
    st_end.bad = 1'b0;
    st_end.colon = 1'b0;
    if (st_q.phase == PhLine) begin
      if (!st_q.bad && st_q.pos == PosVersion) begin
        verdict = VerAccept;
        st_end.phase = PhHead;
      end else begin
        verdict = VerReject;
        st_end.phase = PhFail;
      end
    end else if (st_q.colon) begin
      verdict = VerHdrEnd;
    end else begin
      verdict = VerComplete;
      st_end.phase = PhDone;
    end
  end

  always_comb begin
    st_d = st_q;
    cr_d = cr_q;
    n = 2'd0;
    r0 = '{data: s_axis_tdata, role: RoleIgnored, verdict: VerNone, last: 1'b1};
    r1 = '{data: s_axis_tdata, role: RoleTerm, verdict: VerNone, last: 1'b1};
    if (st_q.phase == PhDone || st_q.phase == PhFail) begin
      n = 2'd1;
    end else if (cr_q) begin
      if (s_axis_tdata == ChLf) begin
        r0 = '{data: ChCr, role: RoleTerm, verdict: VerNone, last: 1'b0};
        r1.verdict = verdict;
        n = 2'd2;
        st_d = st_end;
        cr_d = 1'b0;
      end else if (s_axis_tdata == ChCr) begin
        r0 = '{data: ChCr, role: t_cr.role, verdict: VerNone, last: 1'b1};
        n = 2'd1;
        st_d = t_cr.st;
      end else begin
        r0 = '{data: ChCr, role: t_cr.role, verdict: VerNone, last: 1'b0};
        r1.role = t_after_cr.role;
        n = 2'd2;
        st_d = t_after_cr.st;
        cr_d = 1'b0;
      end
    end else if (s_axis_tdata == ChCr) begin
      cr_d = 1'b1;
    end else begin
      r0.role = t_plain.role;
      n = 2'd1;
      st_d = t_plain.st;
    end
  end

  always_comb begin
    count_d = count_q;
    if (s_acc) count_d = count_d + {1'b0, n};
    if (m_acc) count_d = count_d - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PhLine, pos: PosMethod, bad: 1'b0, colon: 1'b0};
      cr_q <= 1'b0;
      wr_q <= 2'd0;
      rd_q <= 2'd0;
      count_q <= 3'd0;
    end else begin
      if (s_acc) begin
        st_q <= st_d;
        cr_q <= cr_d;
        wr_q <= wr_q + n;
      end
      if (m_acc) rd_q <= rd_q + 2'd1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && n != 2'd0) fifo_q[wr_q] <= r0;
    if (s_acc && n == 2'd2) fifo_q[wr_q + 2'd1] <= r1;
  end

  assign head = fifo_q[rd_q];
  assign m_axis_tdata = head.data;
  assign m_axis_tuser = {head.verdict, head.role};
  assign m_axis_tlast = head.last;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4) else $error("result queue overflow");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PhDone) |=> (st_q.phase == PhDone))
    else $error("completed request left done phase");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PhFail) |=> (st_q.phase == PhFail))
    else $error("rejected request left fail phase");

  a_cr_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_q |-> (st_q.phase == PhLine || st_q.phase == PhHead))
    else $error("CR held outside an active line");

  a_verdict_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && head.verdict != VerNone) |-> (head.role == RoleTerm && head.last))
    else $error("verdict on a beat that is not a line end");
`endif

endmodule
